FILE: src/pidl_pkg.sv
`default_nettype none
package pidl_pkg;

   localparam int CAPACITY_ENTRIES = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_TRAVERSE = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_TRAVERSE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] cnt;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: src/positional_insert_delete_list_core.sv
// Insert, delete and unused kinds: one word, registered in the next cycle.
// Traverse: count words (one word, registered in the next cycle, if empty); the
// request enters the traverse state, which emits the head word and rotates the cell
// chain, one word a cycle while the output is not stalled.
// A new request is taken once the previous one has issued its last word.
// Reset (synchronous, active high) empties the list; cell contents are not cleared.
`default_nettype none
module positional_insert_delete_list_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [1:0]                          req_kind,
   input  wire [pidl_pkg::IDX_W-1:0]          req_position,
   input  wire signed [pidl_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0] rsp_element,
   output logic [pidl_pkg::IDX_W-1:0]         rsp_element_index,
   output logic [pidl_pkg::CNT_W-1:0]         rsp_length,
   output logic                               rsp_last
);

   localparam int CAP = pidl_pkg::CAPACITY_ENTRIES;

   pidl_pkg::cell_cmd_type      cmd;
   logic [pidl_pkg::DATA_W-1:0] cell_value [CAP];
   logic [pidl_pkg::DATA_W-1:0] left_value [CAP];
   logic [pidl_pkg::DATA_W-1:0] right_value [CAP];

   pidl_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_element       (rsp_element),
      .rsp_element_index (rsp_element_index),
      .rsp_length        (rsp_length),
      .rsp_last          (rsp_last),
      .head_value        (cell_value[0]),
      .cmd               (cmd)
   );

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_value[i] = '0;
      end else begin : g_left
         assign left_value[i] = cell_value[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign right_value[i] = '0;
      end else begin : g_right
         assign right_value[i] = cell_value[i+1];
      end

      pidl_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_value[i]),
         .right_value (right_value[i]),
         .head_value  (cell_value[0]),
         .value       (cell_value[i])
      );
   end

endmodule
`default_nettype wire

FILE: src/pidl_cell.sv
`default_nettype none
module pidl_cell #(
   parameter int INDEX = 0
) (
   input  wire                         clock,
   input  pidl_pkg::cell_cmd_type      cmd,
   input  wire [pidl_pkg::DATA_W-1:0]  left_value,
   input  wire [pidl_pkg::DATA_W-1:0]  right_value,
   input  wire [pidl_pkg::DATA_W-1:0]  head_value,
   output logic [pidl_pkg::DATA_W-1:0] value
);

   localparam logic [pidl_pkg::CNT_W-1:0] MY_IDX = pidl_pkg::CNT_W'(INDEX);
   localparam logic [pidl_pkg::CNT_W-1:0] MY_NEXT = pidl_pkg::CNT_W'(INDEX + 1);

   logic [pidl_pkg::DATA_W-1:0] value_ff;
   logic [pidl_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         pidl_pkg::CELL_INSERT: begin
            if (MY_IDX == cmd.pos) begin
               value_in = cmd.value;
            end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt) begin
               value_in = left_value;
            end
         end
         pidl_pkg::CELL_DELETE: begin
            if (MY_IDX >= cmd.pos && MY_NEXT < cmd.cnt) begin
               value_in = right_value;
            end
         end
         pidl_pkg::CELL_ROTATE: begin
            // the head of the held list wraps around to its tail
            if (MY_NEXT < cmd.cnt) begin
               value_in = right_value;
            end else if (MY_NEXT == cmd.cnt) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

FILE: src/pidl_ctrl.sv
`default_nettype none
module pidl_ctrl (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [1:0]                          req_kind,
   input  wire [pidl_pkg::IDX_W-1:0]          req_position,
   input  wire signed [pidl_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0] rsp_element,
   output logic [pidl_pkg::IDX_W-1:0]         rsp_element_index,
   output logic [pidl_pkg::CNT_W-1:0]         rsp_length,
   output logic                               rsp_last,
   input  wire [pidl_pkg::DATA_W-1:0]         head_value,
   output pidl_pkg::cell_cmd_type             cmd
);

   localparam logic [pidl_pkg::CNT_W-1:0] CAP =
      pidl_pkg::CNT_W'(pidl_pkg::CAPACITY_ENTRIES);
   localparam logic [pidl_pkg::CNT_W-1:0] ONE = pidl_pkg::CNT_W'(1);

   pidl_pkg::state_type state_ff, state_in;
   logic [pidl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [pidl_pkg::IDX_W-1:0] k_ff, k_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [pidl_pkg::DATA_W-1:0] element_ff, element_in;
   logic [pidl_pkg::IDX_W-1:0]  index_ff, index_in;
   logic [pidl_pkg::CNT_W-1:0]  length_ff, length_in;
   logic                        last_ff, last_in;

   logic                        out_free;
   logic                        trav_last;
   logic [pidl_pkg::CNT_W-1:0]  pos_ext;
   logic [pidl_pkg::CNT_W-1:0]  ins_pos;
   logic [pidl_pkg::CNT_W-1:0]  del_pos;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pos_ext = {1'b0, req_position};
      ins_pos = (pos_ext > count_ff) ? count_ff : pos_ext;
      del_pos = (pos_ext > count_ff - ONE) ? count_ff - ONE : pos_ext;
      trav_last = ({1'b0, k_ff} + ONE) == count_ff;

      state_in = state_ff;
      count_in = count_ff;
      k_in = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      element_in = element_ff;
      index_in = index_ff;
      length_in = length_ff;
      last_in = last_ff;
      req_stall = 1'b1;
      cmd.op = pidl_pkg::CELL_HOLD;
      cmd.pos = '0;
      cmd.cnt = count_ff;
      cmd.value = req_value;

      case (state_ff)
         pidl_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               rsp_valid_in = 1'b1;
               status_in = pidl_pkg::STATUS_OK;
               element_in = '0;
               index_in = '0;
               length_in = count_ff;
               last_in = 1'b1;
               case (req_kind)
                  pidl_pkg::KIND_INSERT: begin
                     if (count_ff >= CAP) begin
                        status_in = pidl_pkg::STATUS_OVERFLOW;
                     end else begin
                        cmd.op = pidl_pkg::CELL_INSERT;
                        cmd.pos = ins_pos;
                        count_in = count_ff + ONE;
                        length_in = count_ff + ONE;
                     end
                  end
                  pidl_pkg::KIND_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = pidl_pkg::STATUS_UNDERFLOW;
                     end else begin
                        cmd.op = pidl_pkg::CELL_DELETE;
                        cmd.pos = del_pos;
                        count_in = count_ff - ONE;
                        length_in = count_ff - ONE;
                     end
                  end
                  pidl_pkg::KIND_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = pidl_pkg::STATUS_EMPTY;
                     end else begin
                        // words come out of the traverse state instead
                        rsp_valid_in = 1'b0;
                        state_in = pidl_pkg::ST_TRAVERSE;
                        k_in = '0;
                     end
                  end
                  default: begin
                     status_in = pidl_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         pidl_pkg::ST_TRAVERSE: begin
            if (out_free) begin
               // emit the head, rotate the list by one
               rsp_valid_in = 1'b1;
               status_in = pidl_pkg::STATUS_OK;
               element_in = head_value;
               index_in = k_ff;
               length_in = count_ff;
               last_in = trav_last;
               cmd.op = pidl_pkg::CELL_ROTATE;
               k_in = k_ff + 1'b1;
               if (trav_last) begin
                  state_in = pidl_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pidl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidl_pkg::ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      status_ff <= status_in;
      element_ff <= element_in;
      index_ff <= index_in;
      length_ff <= length_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_element = element_ff;
   assign rsp_element_index = index_ff;
   assign rsp_length = length_ff;
   assign rsp_last = last_ff;

endmodule
`default_nettype wire
